// ----- design/kway_sorted_list_merge_top_n_macros.svh -----
// Assertion macros shared by the checkers of the k-way merge block.
// Depends on nothing; included by the checker file.
`ifndef KWAY_SORTED_LIST_MERGE_TOP_N_MACROS_SVH
`define KWAY_SORTED_LIST_MERGE_TOP_N_MACROS_SVH

// Check a property on the rising clock, held off while reset is high.
`define KSLM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock, including the reset cycles.
`define KSLM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/kslm_pkg.sv -----
// Shared types and constants of the k-way sorted list merge block.
// Depends on nothing.
package kslm_pkg;

   localparam int KEY_W        = 32;
   localparam int MAX_LISTS    = 4;
   localparam int LIST_IDX_W   = 2;
   localparam int DEF_NUM_LISTS = 4;
   localparam int DEF_LIST_LEN  = 16;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PICK,
      ST_FETCH
   } merge_state_type;

   // Winner of one head comparison round.
   typedef struct packed {
      logic [LIST_IDX_W-1:0] sel;
      logic [KEY_W-1:0]      key;
   } pick_type;

endpackage

// ----- design/kslm_if.sv -----
// Channel interfaces of the k-way merge block: load items and merged keys.
// Depends on kslm_pkg.
interface kslm_req_if;
   logic                    valid;
   logic                    ready;
   logic [kslm_pkg::KEY_W-1:0] key_list0;
   logic [kslm_pkg::KEY_W-1:0] key_list1;
   logic [kslm_pkg::KEY_W-1:0] key_list2;
   logic [kslm_pkg::KEY_W-1:0] key_list3;

   modport source (output valid, key_list0, key_list1, key_list2, key_list3, input ready);
   modport sink   (input valid, key_list0, key_list1, key_list2, key_list3, output ready);
endinterface

interface kslm_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [kslm_pkg::KEY_W-1:0] smallest_key;
   logic                    is_final;

   modport source (output valid, smallest_key, is_final, input ready);
   modport sink   (input valid, smallest_key, is_final, output ready);
endinterface

// ----- design/kslm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kslm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kslm_pick.sv -----
// Head selector: smallest live head key, ties to the lowest list index.
// Depends on kslm_pkg.
module kslm_pick #(
   parameter int NUM_LISTS = kslm_pkg::DEF_NUM_LISTS
) (
   input  logic [NUM_LISTS-1:0][kslm_pkg::KEY_W-1:0] heads,
   input  logic [NUM_LISTS-1:0]                      live,
   output kslm_pkg::pick_type                        pick
);

   always_comb begin
      logic found;
      found = 1'b0;
      pick  = '0;
      for (int s = 0; s < NUM_LISTS; s++) begin
         // strict less keeps the earlier list on a tie
         if (live[s] && (!found || heads[s] < pick.key)) begin
            found    = 1'b1;
            pick.sel = kslm_pkg::LIST_IDX_W'(s);
            pick.key = heads[s];
         end
      end
   end

endmodule

// ----- design/kway_sorted_list_merge_top_n.sv -----
// Top level of the k-way sorted list merge block.
// Depends on kslm_pkg, kslm_if, kslm_ram and kslm_pick.
//
// The block takes LIST_LEN load transfers, each carrying the next key of every
// one of NUM_LISTS ascending lists, and stores them row by row in one RAM (row
// = load index, one key per list). Loading runs at one transfer per cycle.
// After the last load of a group the block stops taking loads and merges:
// each step picks the smallest live list head (ties go to the lower list,
// used-up lists drop out), sends that key and fetches the list's next key
// from the RAM. The RAM's read port is registered, so each pick but the
// group's last is followed by a fetch state that writes the read key into
// the winner's head before the next pick; a stalled result side holds the
// merge. Exactly LIST_LEN keys come out per group, the last with is_final
// set. The result register lets the next group's first load transfer while
// the last key still waits. Keys are compared as unsigned 32-bit patterns.
module kway_sorted_list_merge_top_n #(
   parameter int NUM_LISTS = kslm_pkg::DEF_NUM_LISTS,
   parameter int LIST_LEN  = kslm_pkg::DEF_LIST_LEN
) (
   input  logic              clock,
   input  logic              reset,
   kslm_req_if.sink          req_chan,
   kslm_rsp_if.source        rsp_chan
);

   localparam int KEY_W  = kslm_pkg::KEY_W;
   localparam int ADDR_W = $clog2(LIST_LEN);
   localparam int PTR_W  = $clog2(LIST_LEN + 1);
   localparam int SEL_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int ROW_W  = NUM_LISTS * KEY_W;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LIST_LEN - 1);
   localparam logic [PTR_W-1:0]  PTR_END  = PTR_W'(LIST_LEN);

   kslm_pkg::merge_state_type state_ff, state_in;

   logic [ADDR_W-1:0]                  load_cnt_ff, load_cnt_in;
   logic [ADDR_W-1:0]                  emit_cnt_ff, emit_cnt_in;
   logic [NUM_LISTS-1:0][PTR_W-1:0]    ptr_ff, ptr_in;
   logic [NUM_LISTS-1:0][KEY_W-1:0]    head_ff, head_in;
   logic [SEL_W-1:0]                   sel_ff, sel_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]                   rsp_key_ff, rsp_key_in;
   logic                               rsp_final_ff, rsp_final_in;

   logic [kslm_pkg::MAX_LISTS-1:0][KEY_W-1:0] req_keys;
   logic [NUM_LISTS-1:0][KEY_W-1:0]           wr_row;
   logic [NUM_LISTS-1:0][KEY_W-1:0]           rd_row;
   logic [ROW_W-1:0]                          rd_data;
   logic [NUM_LISTS-1:0]                      live;
   kslm_pkg::pick_type                        pick;
   logic [SEL_W-1:0]                          pick_sel;
   logic [PTR_W-1:0]                          ptr_adv;
   logic [ADDR_W-1:0]                         rd_addr;
   logic                                      load_xfer;
   logic                                      last_load;
   logic                                      out_free;
   logic                                      emit;

   // gather the load payload; lists past NUM_LISTS are dropped
   assign req_keys[0] = req_chan.key_list0;
   assign req_keys[1] = req_chan.key_list1;
   assign req_keys[2] = req_chan.key_list2;
   assign req_keys[3] = req_chan.key_list3;

   always_comb begin
      for (int s = 0; s < NUM_LISTS; s++) begin
         wr_row[s] = req_keys[s];
      end
   end

   // a list is live until its pointer runs off the end
   always_comb begin
      for (int s = 0; s < NUM_LISTS; s++) begin
         live[s] = (ptr_ff[s] < PTR_END);
      end
   end

   kslm_pick #(
      .NUM_LISTS (NUM_LISTS)
   ) u_pick (
      .heads (head_ff),
      .live  (live),
      .pick  (pick)
   );

   assign pick_sel = pick.sel[SEL_W-1:0];
   assign ptr_adv  = ptr_ff[pick_sel] + PTR_W'(1);
   // the fetch past a list's end is never used; keep the address in range
   assign rd_addr  = (ptr_adv < PTR_END) ? ptr_adv[ADDR_W-1:0] : '0;

   assign load_xfer = req_chan.valid && req_chan.ready;
   assign last_load = load_xfer && (load_cnt_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   kslm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LIST_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (load_cnt_ff),
      .wr_data (wr_row),
      .rd_en   (emit),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_row = rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kslm_pkg::ST_LOAD: begin
            if (last_load) begin
               state_in = kslm_pkg::ST_PICK;
            end
         end
         kslm_pkg::ST_PICK: begin
            if (out_free) begin
               state_in = (emit_cnt_ff == LAST_IDX) ? kslm_pkg::ST_LOAD
                                                    : kslm_pkg::ST_FETCH;
            end
         end
         kslm_pkg::ST_FETCH: begin
            state_in = kslm_pkg::ST_PICK;
         end
         default: begin
            state_in = kslm_pkg::ST_LOAD;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      emit           = 1'b0;
      case (state_ff)
         kslm_pkg::ST_LOAD:  req_chan.ready = 1'b1;
         kslm_pkg::ST_PICK:  emit           = out_free;
         kslm_pkg::ST_FETCH: emit           = 1'b0;
         default:            emit           = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_final_in = rsp_final_ff;

      // advance the load row; row 0 also seeds the head cache
      if (load_xfer) begin
         load_cnt_in = last_load ? '0 : load_cnt_ff + ADDR_W'(1);
         if (load_cnt_ff == '0) begin
            head_in = wr_row;
         end
      end
      if (last_load) begin
         ptr_in      = '0;
         emit_cnt_in = '0;
      end

      // drop the held key once it transfers
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // send the winner, advance its pointer and fetch its next key
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_key_in       = pick.key;
         rsp_final_in     = (emit_cnt_ff == LAST_IDX);
         ptr_in[pick_sel] = ptr_adv;
         sel_in           = pick_sel;
         emit_cnt_in      = emit_cnt_ff + ADDR_W'(1);
      end

      // refill the winner's head from the row read last cycle
      if (state_ff == kslm_pkg::ST_FETCH) begin
         head_in[sel_ff] = rd_row[sel_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kslm_pkg::ST_LOAD;
         load_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      sel_ff       <= sel_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.smallest_key = rsp_key_ff;
   assign rsp_chan.is_final     = rsp_final_ff;

endmodule

// ----- design/kslm_check.sv -----
// Port-level checker for the k-way merge block, bound to its top level.
// Depends on kslm_pkg and kway_sorted_list_merge_top_n_macros.svh.
`include "kway_sorted_list_merge_top_n_macros.svh"

module kslm_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [kslm_pkg::KEY_W-1:0] rsp_smallest_key,
   input logic                       rsp_is_final
);

   // hold a stalled key and its marker until it transfers
   `KSLM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smallest_key) && $stable(rsp_is_final), "stalled result changed")

   // no load is taken while a group's merge is still running
   `KSLM_ASSERT(a_no_load_mid_merge, clock, reset, rsp_valid && !rsp_is_final |-> !req_ready, "load taken during merge")

   // reset leaves no result pending
   `KSLM_ASSERT_ALWAYS(a_reset_clears, clock, $fell(reset) |-> !rsp_valid, "result valid after reset")

   // a load offered during a merge waits
   `KSLM_ASSERT(a_merge_blocks_req, clock, reset, req_valid && rsp_valid && !rsp_is_final |-> !(req_valid && req_ready), "load transfer during merge")

endmodule

bind kway_sorted_list_merge_top_n kslm_check u_kslm_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_smallest_key (rsp_chan.smallest_key),
   .rsp_is_final     (rsp_chan.is_final)
);

// ----- tb/sv/tb_kway_sorted_list_merge_top_n.sv -----
// Self-checking bench for the k-way sorted list merge: a directed load group, then random
// groups, every merged key compared in order against the greedy head-pick model or a pinned key.
// Depends on kslm_pkg, the kslm_if channel interfaces and kway_sorted_list_merge_top_n.
module tb_kway_sorted_list_merge_top_n;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LISTS         = kslm_pkg::DEF_NUM_LISTS;
   localparam int DEPTH         = kslm_pkg::DEF_LIST_LEN;
   localparam int RANDOM_GROUPS = 6;
   localparam int CALM_GROUP    = 3;        // random group run with no idling on either side
   localparam int IDLE_PCT      = 19;
   localparam int DRAIN_CYCLES  = 4 * DEPTH;
   localparam int CYCLE_LIMIT   = 200000;

   typedef logic [kslm_pkg::KEY_W-1:0] key_type;

   // One merged key as the result channel should carry it.
   typedef struct packed {
      key_type key;
      logic    is_last;
   } merged_key_type;

   // Per-load note: a pinned row carries the key expected at the same position of the
   // merged output, typed in by hand instead of being predicted.
   typedef struct packed {
      bit      pinned;
      key_type key;
      logic    is_last;
   } row_note_type;

   typedef struct packed {
      key_type      k0;
      key_type      k1;
      key_type      k2;
      key_type      k3;
      row_note_type note;
   } load_row_type;

   // Shapes of a random group: most are well-formed ascending lists.
   typedef enum int {
      WIDE_SORTED,     // ascending, spread over the whole 32-bit range
      TIGHT_SORTED,    // ascending, tiny steps, so heads tie often
      RAW_NOISE        // unsorted patterns, greedy order only
   } group_shape_type;

   logic clock = 1'b0;
   logic reset;

   kslm_req_if req_bus ();
   kslm_rsp_if rsp_bus ();

   kway_sorted_list_merge_top_n #(
      .NUM_LISTS (LISTS),
      .LIST_LEN  (DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Model state: the group being loaded and the keys still owed by the block.
   key_type        held_keys [LISTS][DEPTH];
   row_note_type   held_notes [DEPTH];
   int             fill_count = 0;
   row_note_type   row_notes [$];
   merged_key_type merged_key_queue [$];

   bit          calm_phase = 1'b0;
   int          errors = 0;
   int          loads_taken = 0;
   int          keys_checked = 0;
   int          groups_sent = 0;
   int          cycle_count = 0;

   load_row_type directed_rows [DEPTH];

   // Merge the loaded group the way the block should: at each of DEPTH steps take the
   // smallest live head, lowest list on a tie, and advance that list. Pinned rows
   // replace the prediction with their typed-in key.
   function automatic void merge_loaded_lists();
      int unsigned    head [LISTS];
      int             best;
      merged_key_type item;
      for (int s = 0; s < LISTS; s++)
         head[s] = 0;
      for (int k = 0; k < DEPTH; k++) begin
         best = -1;
         for (int s = 0; s < LISTS; s++) begin
            // skip a used-up list; strict compare keeps the lower index on a tie
            if (head[s] < DEPTH &&
                (best < 0 || held_keys[s][head[s]] < held_keys[best][head[best]]))
               best = s;
         end
         item.key     = held_keys[best][head[best]];
         item.is_last = (k == DEPTH - 1);
         head[best]++;
         if (held_notes[k].pinned) begin
            item.key     = held_notes[k].key;
            item.is_last = held_notes[k].is_last;
         end
         merged_key_queue.push_back(item);
      end
   endfunction

   // Offer one load transfer and hold it until the block takes it. Idle cycles go in
   // front at random unless the calm phase is on.
   task automatic push_load(input key_type k0, input key_type k1,
                            input key_type k2, input key_type k3,
                            input row_note_type note);
      row_notes.push_back(note);
      while (!calm_phase && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.key_list0 <= k0;
      req_bus.key_list1 <= k1;
      req_bus.key_list2 <= k2;
      req_bus.key_list3 <= k3;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   // Watch both channels on the rising edge. Load transfers feed the model; each
   // result transfer is checked against the oldest owed key. The result side's
   // ready is also driven from here, with random stalls.
   always @(posedge clock) begin : watch_bus
      row_note_type   note;
      merged_key_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            note = row_notes.pop_front();
            held_keys[0][fill_count] = req_bus.key_list0;
            held_keys[1][fill_count] = req_bus.key_list1;
            held_keys[2][fill_count] = req_bus.key_list2;
            held_keys[3][fill_count] = req_bus.key_list3;
            held_notes[fill_count]   = note;
            loads_taken++;
            fill_count++;
            // the last load of a group starts the merge
            if (fill_count == DEPTH) begin
               merge_loaded_lists();
               fill_count = 0;
               groups_sent++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (merged_key_queue.size() == 0) begin
               $display("%0t: unexpected merged key: expected none, got key %h last %0b",
                        $time, rsp_bus.smallest_key, rsp_bus.is_final);
               errors++;
            end else begin
               want = merged_key_queue.pop_front();
               keys_checked++;
               if (rsp_bus.smallest_key !== want.key) begin
                  $display("%0t: smallest_key mismatch: expected %h, got %h",
                           $time, want.key, rsp_bus.smallest_key);
                  errors++;
               end
               if (rsp_bus.is_final !== want.is_last) begin
                  $display("%0t: is_final mismatch: expected %0b, got %0b",
                           $time, want.is_last, rsp_bus.is_final);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d keys still owed",
                  cycle_count, merged_key_queue.size());
         $display("tb_kway_sorted_list_merge_top_n NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      key_type         lanes [LISTS][DEPTH];
      longint unsigned acc;
      int unsigned     span;
      int unsigned     roll;
      group_shape_type shape;
      row_note_type    free_note;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.key_list0 = '0;
      req_bus.key_list1 = '0;
      req_bus.key_list2 = '0;
      req_bus.key_list3 = '0;
      rsp_bus.ready     = 1'b0;
      free_note         = '{1'b0, '0, 1'b0};

      // Directed group. Lists 1 and 2 both count up from zero and tie at every step,
      // so the merged output reads 0,0,1,1,...,7,7. List 0 holds the all-ones pattern
      // (sign bit set) and list 3 runs from +inf into the NaN patterns: both compare
      // as large unsigned values and must never be picked. Each row pins the key due
      // at its own output position.
      directed_rows = '{
         '{32'hFFFF_FFFF, 32'd0,  32'd0,  32'h7F80_0000, '{1'b1, 32'd0, 1'b0}},
         '{32'hFFFF_FFFF, 32'd1,  32'd1,  32'h7F80_0001, '{1'b1, 32'd0, 1'b0}},
         '{32'hFFFF_FFFF, 32'd2,  32'd2,  32'h7F80_0002, '{1'b1, 32'd1, 1'b0}},
         '{32'hFFFF_FFFF, 32'd3,  32'd3,  32'h7F80_0003, '{1'b1, 32'd1, 1'b0}},
         '{32'hFFFF_FFFF, 32'd4,  32'd4,  32'h7F80_0004, '{1'b1, 32'd2, 1'b0}},
         '{32'hFFFF_FFFF, 32'd5,  32'd5,  32'h7F80_0005, '{1'b1, 32'd2, 1'b0}},
         '{32'hFFFF_FFFF, 32'd6,  32'd6,  32'h7F80_0006, '{1'b1, 32'd3, 1'b0}},
         '{32'hFFFF_FFFF, 32'd7,  32'd7,  32'h7F80_0007, '{1'b1, 32'd3, 1'b0}},
         '{32'hFFFF_FFFF, 32'd8,  32'd8,  32'h7F80_0008, '{1'b1, 32'd4, 1'b0}},
         '{32'hFFFF_FFFF, 32'd9,  32'd9,  32'h7F80_0009, '{1'b1, 32'd4, 1'b0}},
         '{32'hFFFF_FFFF, 32'd10, 32'd10, 32'h7F80_000A, '{1'b1, 32'd5, 1'b0}},
         '{32'hFFFF_FFFF, 32'd11, 32'd11, 32'h7F80_000B, '{1'b1, 32'd5, 1'b0}},
         '{32'hFFFF_FFFF, 32'd12, 32'd12, 32'h7F80_000C, '{1'b1, 32'd6, 1'b0}},
         '{32'hFFFF_FFFF, 32'd13, 32'd13, 32'h7F80_000D, '{1'b1, 32'd6, 1'b0}},
         '{32'hFFFF_FFFF, 32'd14, 32'd14, 32'h7F80_000E, '{1'b1, 32'd7, 1'b0}},
         '{32'hFFFF_FFFF, 32'd15, 32'd15, 32'h7F80_000F, '{1'b1, 32'd7, 1'b1}}
      };

      // Hold reset high, then release it once.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_load(directed_rows[i].k0, directed_rows[i].k1, directed_rows[i].k2,
                   directed_rows[i].k3, directed_rows[i].note);

      // Random groups. Build each list first, then walk it row by row. The first two
      // groups force a tie-heavy and an unsorted shape; the rest are drawn, weighted
      // toward well-formed ascending lists.
      for (int g = 0; g < RANDOM_GROUPS; g++) begin
         calm_phase <= (g == CALM_GROUP);
         roll = $urandom_range(0, 9);
         if (g == 0)
            shape = TIGHT_SORTED;
         else if (g == 1)
            shape = RAW_NOISE;
         else if (roll < 6)
            shape = WIDE_SORTED;
         else if (roll < 8)
            shape = TIGHT_SORTED;
         else
            shape = RAW_NOISE;
         span = (shape == WIDE_SORTED) ? 32'h1000_0000 : 32'd3;
         for (int s = 0; s < LISTS; s++) begin
            acc = $urandom_range(0, span);
            for (int r = 0; r < DEPTH; r++) begin
               if (shape == RAW_NOISE)
                  lanes[s][r] = $urandom();
               else  // saturate
                  lanes[s][r] = (acc > 64'hFFFF_FFFF) ? '1 : acc[kslm_pkg::KEY_W-1:0];
               acc += $urandom_range(0, span);
            end
         end
         for (int r = 0; r < DEPTH; r++)
            push_load(lanes[0][r], lanes[1][r], lanes[2][r], lanes[3][r], free_note);
      end

      // Drop valid, let every owed key arrive, then give stray results time to show.
      req_bus.valid <= 1'b0;
      calm_phase    <= 1'b0;
      while (merged_key_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d load transfers in %0d groups (tied, unsorted and NaN-pattern keys)",
               loads_taken, groups_sent);
      $display("checked %0d merged keys, %0d mismatches", keys_checked, errors);
      if (errors == 0)
         $display("tb_kway_sorted_list_merge_top_n OK");
      else
         $display("tb_kway_sorted_list_merge_top_n NOT OK");
      $finish;
   end

endmodule
